// ===== hdl/kscd_pkg.sv =====
`default_nettype none

package kscd_pkg;

	// Input item operation codes.
	localparam logic OP_MAP_LOAD = 1'b0;
	localparam logic OP_SCAN     = 1'b1;

	// Fixed storage sizes.
	localparam int FLAG_DEPTH = 16;
	localparam int MAP_DEPTH  = 128;
	localparam int BYTE_BITS  = 8;

	// Held key count and mapped key code types.
	typedef logic [7:0] count_t;
	typedef logic [6:0] code_t;

endpackage

`default_nettype wire

// ===== hdl/kscd_ram.sv =====
`default_nettype none

module kscd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port; read data holds without a read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/key_state_change_detector_unit.sv =====
// Key state change detector.
// Input channel (in_valid/in_ready) carries two kinds of item. A map-load item
// (op = 0) writes the key code of one slot into the key map and is absorbed in
// idle; in_ready stays high after it. A scan item (op = 1) brings one byte
// of the pressed-flag bitmap. The block compares it with the stored byte and
// emits one event per changed bit whose slot is in range and mapped to a
// non-negative code below KEY_CODE_RANGE, lowest bit first.
// Output channel (out_valid/out_ready) carries one event per item, with the
// held key count after that event; last marks the final event of a scan byte.
// A scan item keeps in_ready low for one flag-memory read, then eight key-map
// lookups through the single read port of the map memory, one per cycle while
// no event is stalled, and a drain of the last lookup. Events lag by one event,
// since an event is held until the next one (or the end of the byte) settles last.
// The output register lets the next item in while an event waits. When the
// receiver stalls, the lookup sequence freezes until the waiting event is taken.
// Reset clears the previous-flag store (through per-byte valid bits), the held
// count and side_brain_mode; key map entries must be written before use.
// cfg_wr_en writes side_brain_mode, which clears forward_to_core when set.
`default_nettype none

module key_state_change_detector_unit
	import kscd_pkg::*;
#(
	parameter int ROWS           = 8,
	parameter int COLUMNS        = 8,
	parameter int KEY_CODE_RANGE = 128
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Configuration.
	input  wire logic              cfg_wr_en,
	input  wire logic              cfg_wr_data,
	// Input items.
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              op,
	input  wire logic [6:0]        slot,
	input  wire logic signed [7:0] key_code,
	input  wire logic [3:0]        byte_index,
	input  wire logic [7:0]        state_bits,
	// Result items.
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [6:0]             key_index,
	output logic                   is_down,
	output logic                   forward_to_core,
	output logic [7:0]             pressed_count,
	output logic                   last
);

	localparam int NUM_SLOTS  = 2 * ROWS * COLUMNS;
	localparam int NUM_BYTES  = 2 * ((ROWS * COLUMNS + 7) / 8);
	localparam int COUNT_CAP  = (NUM_SLOTS > 255) ? 255 : NUM_SLOTS;
	localparam int FLAG_AW    = $clog2(FLAG_DEPTH);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FLAGS = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;

	logic [1:0]            state_q;
	logic                  side_brain_q;
	logic [FLAG_DEPTH-1:0] flag_vld_q;
	logic [FLAG_AW-1:0]    bi_q;
	logic [BYTE_BITS-1:0]  nb_q;
	logic [BYTE_BITS-1:0]  chg_q;
	logic [3:0]            rd_j_q;
	logic                  lk_vld_s1;
	logic [2:0]            lk_j_s1;
	count_t                held_count_q;
	logic                  pend_vld_q;
	code_t                 pend_code_q;
	logic                  pend_down_q;
	count_t                pend_count_q;
	logic                  out_valid_q;

	logic                  accept;
	logic                  scan_ok;
	logic [BYTE_BITS-1:0]  flag_rdata;
	logic [BYTE_BITS-1:0]  old_byte;
	logic [BYTE_BITS-1:0]  range_mask;
	logic [7:0]            map_rdata;
	logic                  code_ok;
	logic                  s1_event;
	logic                  finish;
	logic                  need_push;
	logic                  out_free;
	logic                  stall;
	logic                  adv;
	logic                  issue;
	count_t                cnt_next;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign scan_ok  = ({28'd0, byte_index} < 32'(NUM_BYTES));

	// Previous pressed flags, one byte per bitmap byte.
	kscd_ram #(
		.WIDTH (BYTE_BITS),
		.DEPTH (FLAG_DEPTH)
	) u_flag_ram (
		.clk   (clk),
		.we    (state_q == ST_FLAGS),
		.waddr (bi_q),
		.wdata (nb_q),
		.re    (accept && (op == OP_SCAN)),
		.raddr (byte_index),
		.rdata (flag_rdata)
	);

	// Key map, written by map-load items and read once per bit of a scan byte.
	kscd_ram #(
		.WIDTH (8),
		.DEPTH (MAP_DEPTH)
	) u_map_ram (
		.clk   (clk),
		.we    (accept && (op == OP_MAP_LOAD)),
		.waddr (slot),
		.wdata (key_code),
		.re    (issue),
		.raddr ({bi_q, rd_j_q[2:0]}),
		.rdata (map_rdata)
	);

	// A byte that was never written since reset reads as all released.
	assign old_byte = flag_vld_q[bi_q] ? flag_rdata : '0;

	// Bits whose slot lies beyond the slot count give no event.
	always_comb begin
		for (int j = 0; j < BYTE_BITS; j++) begin
			range_mask[j] = ({25'd0, bi_q, 3'(j)} < 32'(NUM_SLOTS));
		end
	end

	// Lookup result: a changed bit with a usable key code makes an event.
	assign code_ok   = !map_rdata[7] && ({1'b0, map_rdata[6:0]} < 8'(KEY_CODE_RANGE));
	assign s1_event  = (state_q == ST_SCAN) && lk_vld_s1 && chg_q[lk_j_s1] && code_ok;
	assign finish    = (state_q == ST_SCAN) && rd_j_q[3] && !lk_vld_s1;
	assign need_push = pend_vld_q && (s1_event || finish);
	assign out_free  = !out_valid_q || out_ready;
	assign stall     = need_push && !out_free;
	assign adv       = (state_q == ST_SCAN) && !stall;
	assign issue     = adv && !rd_j_q[3];

	// Saturating held count after the event found this cycle.
	always_comb begin
		cnt_next = held_count_q;
		if (nb_q[lk_j_s1]) begin
			if (held_count_q < 8'(COUNT_CAP)) begin
				cnt_next = held_count_q + 8'd1;
			end
		end else if (held_count_q != 8'd0) begin
			cnt_next = held_count_q - 8'd1;
		end
	end

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			side_brain_q <= 1'b0;
			flag_vld_q   <= '0;
			rd_j_q       <= '0;
			lk_vld_s1    <= 1'b0;
			held_count_q <= '0;
			pend_vld_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				side_brain_q <= cfg_wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (op == OP_SCAN) && scan_ok) begin
						state_q <= ST_FLAGS;
					end
				end
				ST_FLAGS: begin
					flag_vld_q[bi_q] <= 1'b1;
					rd_j_q           <= '0;
					lk_vld_s1        <= 1'b0;
					state_q          <= ST_SCAN;
				end
				ST_SCAN: begin
					if (adv) begin
						lk_vld_s1 <= issue;
						if (issue) begin
							rd_j_q <= rd_j_q + 4'd1;
						end
						if (s1_event) begin
							held_count_q <= cnt_next;
							pend_vld_q   <= 1'b1;
						end
						if (finish) begin
							pend_vld_q <= 1'b0;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item payload, change mask and pending event fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			bi_q <= byte_index;
			nb_q <= state_bits;
		end
		if (state_q == ST_FLAGS) begin
			chg_q <= (old_byte ^ nb_q) & range_mask;
		end
		if (adv) begin
			lk_j_s1 <= rd_j_q[2:0];
		end
		if (adv && s1_event) begin
			pend_code_q  <= map_rdata[6:0];
			pend_down_q  <= nb_q[lk_j_s1];
			pend_count_q <= cnt_next;
		end
	end

	// Output register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (need_push && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: event fields; last is known once no further event can come.
	always_ff @(posedge clk) begin
		if (need_push && out_free) begin
			key_index       <= pend_code_q;
			is_down         <= pend_down_q;
			forward_to_core <= !side_brain_q;
			pressed_count   <= pend_count_q;
			last            <= finish;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/kscd_checker.sv =====
`default_nettype none

module kscd_checker
	import kscd_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       op,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [6:0] key_index,
	input wire logic       is_down,
	input wire logic       forward_to_core,
	input wire logic [7:0] pressed_count,
	input wire logic       last
);

	// A stalled event holds its fields.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(key_index) && $stable(is_down)
			&& $stable(forward_to_core) && $stable(pressed_count) && $stable(last))
		else $error("stalled event changed");

	// A key-down event always leaves at least one key held.
	a_down_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_down |-> pressed_count != 8'd0)
		else $error("key-down event with zero held count");

	// A map-load item does not block the next item.
	a_map_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == OP_MAP_LOAD) |=> in_ready)
		else $error("input blocked after map load");

endmodule

bind key_state_change_detector_unit kscd_checker u_kscd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.op              (op),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.key_index       (key_index),
	.is_down         (is_down),
	.forward_to_core (forward_to_core),
	.pressed_count   (pressed_count),
	.last            (last)
);

`default_nettype wire
